// File: hw/rtl/lpet_pkg.sv
// ----------------------------------------------------------------------------
// lpet_pkg
// Shared widths, register indexes and sequencer types for the line position
// error tracker.
// ----------------------------------------------------------------------------
package lpet_pkg;

    // Field widths of the ports.
    localparam int SENSOR_W   = 5;
    localparam int ERR_W      = 11;
    localparam int CNT_W      = 8;
    localparam int WGT_W      = 9;
    localparam int STEP_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Default number of fraction bits of the error format.
    localparam int FRAC_BITS_DEF = 8;

    // Filter weight scale and output limits.
    localparam int WGT_SHIFT = 8;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(256);
    localparam int ERR_MAX = 1023;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register reset values.
    localparam logic [WGT_W-1:0]  WGT_RESET  = WGT_W'(179);
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(154);
    localparam logic [STEP_W-1:0] CAP_RESET  = STEP_W'(640);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_CAP      = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SOURCE,
        S_DIFF,
        S_FILTER
    } t_state;

    // Operand selection of the shared multiplier.
    typedef enum logic [1:0] {
        MUL_STEP,
        MUL_RECIP,
        MUL_FILTER
    } t_mul_sel;

    // Control outputs of the sequencer.
    typedef struct packed {
        logic     in_ready;
        logic     out_load;
        t_mul_sel mul_sel;
    } t_ctrl;

endpackage

// File: hw/rtl/line_position_error_tracker.sv
// ----------------------------------------------------------------------------
// line_position_error_tracker
// Turns five active-low line sensor samples into a smoothed, signed fixed
// point line position error, with a growing substitute error while lost.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one 5-bit sensor sample per
//   transfer. Output channel: o_out_valid / i_out_ready carry one result per
//   sample: the smoothed error, a lost flag and the lost sample count.
//   Configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_idx
//   (0 smoothing weight, 1 lost step, 2 lost cap) in the same cycle.
//   Timing: a sample passes the source, difference and filter steps in turn.
//   One shared multiplier serves two steps (substitute magnitude or centroid
//   reciprocal, then the filter), with the difference step between them to
//   form the filter difference. The result is loaded into the output register
//   as the filter step ends; no new sample is taken before the tracker is idle.
//   Stall: the result sits in an output register; a finished sample waits in
//   the filter step until that register is free, and no new sample is taken
//   meanwhile.
//   Reset: the registers return to their defaults, the filter, the lost count
//   and the sign memory clear, and the output valid drops.
// ----------------------------------------------------------------------------
module line_position_error_tracker #(
    parameter int FRAC_BITS = lpet_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lpet_pkg::SENSOR_W-1:0]      i_sensor_levels,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [lpet_pkg::ERR_W-1:0]  o_smoothed_error,
    output logic                               o_line_lost,
    output logic [lpet_pkg::CNT_W-1:0]         o_lost_samples,
    input  logic                               i_cfg_we,
    input  logic [lpet_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpet_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lpet_pkg::*;

    // Used error width, difference width and multiplier operand widths.
    localparam int UW    = (FRAC_BITS + 3 > ERR_W) ? FRAC_BITS + 3 : ERR_W;
    localparam int DW    = UW + 1;
    localparam int AW    = DW;
    localparam int R_SH  = FRAC_BITS + 5;
    localparam int BW    = FRAC_BITS + 7;
    localparam int PW    = AW + BW;

    // Rounded-up reciprocals of the active counts, scaled by 2^R_SH.
    localparam longint ONE_R = longint'(1) << R_SH;
    localparam logic [BW-1:0] RECIP_1 = BW'(ONE_R);
    localparam logic [BW-1:0] RECIP_2 = BW'((ONE_R + 1) / 2);
    localparam logic [BW-1:0] RECIP_3 = BW'((ONE_R + 2) / 3);
    localparam logic [BW-1:0] RECIP_4 = BW'((ONE_R + 3) / 4);
    localparam logic [BW-1:0] RECIP_5 = BW'((ONE_R + 4) / 5);

    // Registers.
    t_state                    r_state, n_state;
    logic [WGT_W-1:0]          r_weight;
    logic [STEP_W-1:0]         r_step;
    logic [STEP_W-1:0]         r_cap;
    logic                      r_lpos;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [ERR_W-1:0]   r_filt;
    logic                      r_lost;
    logic                      r_neg;
    logic [1:0]                r_wmag;
    logic [2:0]                r_count;
    logic signed [UW-1:0]      r_used;
    logic signed [DW-1:0]      r_diff;
    logic                      r_out_valid;
    logic signed [ERR_W-1:0]   r_o_err;
    logic                      r_o_lost;
    logic [CNT_W-1:0]          r_o_samples;

    t_ctrl                     ctrl;
    logic                      accept;

    // Sample decode: active sensors, count and weighted sum as sign and size.
    logic [SENSOR_W-1:0]       active;
    logic [2:0]                count;
    logic [1:0]                pos_w, neg_w, wmag;
    logic                      lost_now;

    assign active   = ~i_sensor_levels;
    assign count    = 3'(active[0]) + 3'(active[1]) + 3'(active[2])
                    + 3'(active[3]) + 3'(active[4]);
    assign pos_w    = {active[4], active[3]};
    assign neg_w    = {active[0], active[1]};
    assign wmag     = (pos_w > neg_w) ? pos_w - neg_w : neg_w - pos_w;
    assign lost_now = (active == '0);
    assign accept   = i_in_valid && ctrl.in_ready;

    // Shared multiplier with operand selection.
    logic signed [AW-1:0]      mul_a;
    logic signed [BW-1:0]      mul_b;
    logic signed [PW-1:0]      mul_p;
    logic [BW-1:0]             recip;
    logic [WGT_W-1:0]          w_eff;

    always_comb begin
        case (r_count)
            3'd2:    recip = RECIP_2;
            3'd3:    recip = RECIP_3;
            3'd4:    recip = RECIP_4;
            3'd5:    recip = RECIP_5;
            default: recip = RECIP_1;
        endcase
    end

    assign w_eff = (r_weight > WGT_ONE) ? WGT_ONE : r_weight;

    always_comb begin
        case (ctrl.mul_sel)
            MUL_STEP: begin
                mul_a = signed'(AW'(r_cnt));
                mul_b = signed'(BW'(r_step));
            end
            MUL_RECIP: begin
                mul_a = signed'(AW'(r_wmag)) <<< FRAC_BITS;
                mul_b = signed'(recip);
            end
            default: begin
                mul_a = r_diff;
                mul_b = signed'(BW'(w_eff));
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Used error: capped substitute while lost, else the signed quotient.
    logic signed [PW-1:0]      cap_ext;
    logic [STEP_W-1:0]         sub_mag;
    logic signed [UW-1:0]      sub_abs;
    logic signed [PW-1:0]      quo;
    logic signed [UW-1:0]      quo_abs;
    logic signed [UW-1:0]      n_used;

    assign cap_ext = signed'(PW'(r_cap));
    assign sub_mag = (mul_p > cap_ext) ? r_cap : mul_p[STEP_W-1:0];
    assign sub_abs = signed'(UW'(sub_mag));
    assign quo     = mul_p >>> R_SH;
    assign quo_abs = quo[UW-1:0];

    always_comb begin
        if (r_lost) begin
            n_used = r_lpos ? sub_abs : -sub_abs;
        end else begin
            n_used = r_neg ? -quo_abs : quo_abs;
        end
    end

    // Filter: used + floor(w * (filtered - used) / 256), then saturation.
    logic signed [DW-1:0]      n_diff;
    logic signed [PW-1:0]      flt_sum;
    logic signed [PW-1:0]      err_hi;
    logic signed [ERR_W-1:0]   n_filt;

    assign n_diff  = DW'(r_filt) - DW'(r_used);
    assign flt_sum = (mul_p >>> WGT_SHIFT) + PW'(r_used);
    assign err_hi  = signed'(PW'(ERR_MAX));

    always_comb begin
        if (flt_sum > err_hi) begin
            n_filt = ERR_W'(ERR_MAX);
        end else if (flt_sum < -err_hi) begin
            n_filt = -(ERR_W'(ERR_MAX));
        end else begin
            n_filt = flt_sum[ERR_W-1:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_SOURCE;
            S_SOURCE: n_state = S_DIFF;
            S_DIFF:   n_state = S_FILTER;
            S_FILTER: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        ctrl = '{in_ready: 1'b0, out_load: 1'b0, mul_sel: MUL_FILTER};
        unique case (r_state)
            S_IDLE:   ctrl.in_ready = 1'b1;
            S_SOURCE: ctrl.mul_sel = r_lost ? MUL_STEP : MUL_RECIP;
            S_DIFF:   ctrl.mul_sel = MUL_FILTER;
            S_FILTER: ctrl.out_load = !r_out_valid || i_out_ready;
        endcase
    end

    // Control state, configuration and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_weight    <= WGT_RESET;
            r_step      <= STEP_RESET;
            r_cap       <= CAP_RESET;
            r_lpos      <= 1'b0;
            r_cnt       <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SMOOTH_WEIGHT: r_weight <= i_cfg_data[WGT_W-1:0];
                    CFG_LOST_STEP:     r_step   <= i_cfg_data[STEP_W-1:0];
                    CFG_LOST_CAP:      r_cap    <= i_cfg_data[STEP_W-1:0];
                    default:           ;
                endcase
            end
            if (accept) begin
                if (lost_now) begin
                    r_cnt <= (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
                end else begin
                    r_cnt  <= '0;
                    r_lpos <= (pos_w > neg_w);
                end
            end
            if (ctrl.out_load) begin
                r_filt      <= n_filt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lost  <= lost_now;
            r_neg   <= (neg_w > pos_w);
            r_wmag  <= wmag;
            r_count <= count;
        end
        if (r_state == S_SOURCE) begin
            r_used <= n_used;
        end
        if (r_state == S_DIFF) begin
            r_diff <= n_diff;
        end
        if (ctrl.out_load) begin
            r_o_err     <= n_filt;
            r_o_lost    <= r_lost;
            r_o_samples <= r_cnt;
        end
    end

    assign o_in_ready       = ctrl.in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_smoothed_error = r_o_err;
    assign o_line_lost      = r_o_lost;
    assign o_lost_samples   = r_o_samples;

    // A transfer in always starts the source step.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SOURCE))
        else $error("input transfer did not start the sequencer");

    // A new result only appears at the end of the filter step.
    a_result_from_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FILTER))
        else $error("result appeared outside the filter step");

    // The lost count is nonzero exactly when the line is lost.
    a_lost_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_lost == (r_o_samples != '0)))
        else $error("lost flag and lost count disagree");

    // The smoothed error never leaves its saturation range.
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_o_err <= ERR_W'(ERR_MAX)) && (r_o_err >= -(ERR_W'(ERR_MAX)))))
        else $error("smoothed error out of range");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line position error tracker. Sensor samples
// are sent through the valid/ready input channel, each transfer is run
// through a local tracking model, and every output transfer is compared field
// by field with the oldest pending result. Phases change the registers and
// the idling pattern of both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpet_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [SENSOR_W-1:0] ALL_DARK = {SENSOR_W{1'b1}};

    typedef struct {
        logic signed [ERR_W-1:0] error;
        logic                    lost;
        logic [CNT_W-1:0]        lost_count;
    } t_result;

    // DUT signals; the ones the bench drives are known from time zero.
    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [SENSOR_W-1:0]        sensor_levels = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [ERR_W-1:0]    smoothed_error;
    logic                       line_lost;
    logic [CNT_W-1:0]           lost_samples;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    // Local copy of the tracker state and registers.
    logic [WGT_W-1:0]           trk_weight = WGT_RESET;
    logic [STEP_W-1:0]          trk_step = STEP_RESET;
    logic [STEP_W-1:0]          trk_cap = CAP_RESET;
    logic                       trk_last_positive = 1'b0;
    logic [CNT_W-1:0]           trk_lost_count = '0;
    logic signed [ERR_W-1:0]    trk_filtered = '0;

    // Stimulus and scoreboard bookkeeping.
    logic [SENSOR_W-1:0]        pending_samples[$];
    t_result                    expected_results[$];
    int                         samples_queued = 0;
    int                         samples_taken = 0;
    int                         results_seen = 0;
    int                         error_count = 0;
    int                         cycle_count = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    logic                       in_xfer = 1'b0;

    line_position_error_tracker u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_sensor_levels (sensor_levels),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_smoothed_error(smoothed_error),
        .o_line_lost     (line_lost),
        .o_lost_samples  (lost_samples),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advances the tracking model by one sample and returns its result.
    function automatic t_result track_position(input logic [SENSOR_W-1:0] levels);
        logic [SENSOR_W-1:0] active;
        int      weighted_sum;
        int      active_count;
        int      used_error;
        int      magnitude;
        longint  weight;
        longint  blend;
        longint  next_filtered;
        t_result res;
        active = ~levels;
        weighted_sum = 0;
        active_count = 0;
        for (int s = 0; s < SENSOR_W; s++) begin
            if (active[s]) begin
                active_count++;
                weighted_sum += s - 2;
            end
        end
        if (active_count == 0) begin
            if (trk_lost_count != CNT_MAX) begin
                trk_lost_count++;
            end
            magnitude = int'(trk_step) * int'(trk_lost_count);
            if (magnitude > int'(trk_cap)) begin
                magnitude = int'(trk_cap);
            end
            used_error = trk_last_positive ? magnitude : -magnitude;
        end else begin
            trk_lost_count = '0;
            // Signed integer division truncates toward zero.
            used_error = (weighted_sum * (1 << FRAC)) / active_count;
            trk_last_positive = (used_error > 0);
        end
        // First-order filter; a weight above one holds the value.
        weight = (trk_weight > WGT_ONE) ? longint'(WGT_ONE) : longint'(trk_weight);
        blend = weight * longint'(trk_filtered)
              + (longint'(WGT_ONE) - weight) * longint'(used_error);
        next_filtered = blend >>> WGT_SHIFT;
        if (next_filtered > ERR_MAX) begin
            next_filtered = ERR_MAX;
        end
        if (next_filtered < -ERR_MAX) begin
            next_filtered = -ERR_MAX;
        end
        trk_filtered = ERR_W'(next_filtered);
        res.error = trk_filtered;
        res.lost = (active_count == 0);
        res.lost_count = trk_lost_count;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        error_count++;
    endtask

    // Writes one register and mirrors it into the tracking model.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_SMOOTH_WEIGHT: trk_weight = value[WGT_W-1:0];
            CFG_LOST_STEP:     trk_step = value[STEP_W-1:0];
            CFG_LOST_CAP:      trk_cap = value[STEP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(input logic [SENSOR_W-1:0] levels);
        pending_samples.push_back(levels);
        samples_queued++;
    endtask

    // Runs of line-seen samples and lost runs follow in random order, now and then
    // a lost run long enough to saturate the lost counter.
    task automatic queue_random_samples(input int n_items);
        int added;
        int run_len;
        added = 0;
        while (added < n_items) begin
            if ($urandom_range(9, 0) < 6) begin
                run_len = $urandom_range(8, 1);
                for (int k = 0; k < run_len; k++) begin
                    queue_sample(SENSOR_W'($urandom_range(30, 0)));
                end
            end else begin
                run_len = ($urandom_range(39, 0) == 0) ? $urandom_range(270, 250)
                                                       : $urandom_range(12, 1);
                for (int k = 0; k < run_len; k++) begin
                    queue_sample(ALL_DARK);
                end
            end
            added += run_len;
        end
    endtask

    // Waits until every sample is taken and every result has arrived.
    task automatic drain;
        while (samples_taken != samples_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(input int weight, input int step, input int cap,
                             input int send_pct, input int recv_pct, input int n_items);
        write_reg(CFG_SMOOTH_WEIGHT, CFG_DATA_W'(weight));
        write_reg(CFG_LOST_STEP, CFG_DATA_W'(step));
        write_reg(CFG_LOST_CAP, CFG_DATA_W'(cap));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_samples(n_items);
        drain();
    endtask

    // Input driver: a new sample goes out only after the last one transferred.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_valid || in_xfer) begin
                if (pending_samples.size() != 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    sensor_levels <= pending_samples.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Monitor: checks output transfers, then predicts accepted inputs.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", int'(smoothed_error), 0);
            end else begin
                want = expected_results.pop_front();
                if (smoothed_error !== want.error) begin
                    report_mismatch("smoothed_error", int'(smoothed_error),
                                    int'(want.error));
                end
                if (line_lost !== want.lost) begin
                    report_mismatch("line_lost", int'(line_lost), int'(want.lost));
                end
                if (lost_samples !== want.lost_count) begin
                    report_mismatch("lost_samples", int'(lost_samples),
                                    int'(want.lost_count));
                end
            end
            results_seen++;
        end
        if (i_rst_n && in_valid && in_ready) begin
            expected_results.push_back(track_position(sensor_levels));
            samples_taken++;
        end
        in_xfer <= i_rst_n && in_valid && in_ready;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("** line_position_error_tracker: FAILED **");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under reset defaults, no idling.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Lost right after reset: the substitute is negative and grows.
        repeat (3) queue_sample(ALL_DARK);
        // Each sensor alone, from far left to far right.
        queue_sample(5'h1E);
        queue_sample(5'h1D);
        queue_sample(5'h1B);
        queue_sample(5'h17);
        queue_sample(5'h0F);
        // Lost after a positive error gives a positive substitute.
        repeat (2) queue_sample(ALL_DARK);
        // All sensors: a zero error clears the sign, so lost goes negative.
        queue_sample(5'h00);
        queue_sample(ALL_DARK);
        // Truncation toward zero on both signs, and assorted pairs.
        queue_sample(5'h0C);
        queue_sample(5'h09);
        queue_sample(5'h1C);
        queue_sample(5'h13);
        queue_sample(5'h03);
        queue_sample(5'h16);
        queue_sample(5'h18);
        queue_sample(5'h07);
        queue_sample(5'h11);
        queue_sample(5'h01);
        queue_sample(5'h10);
        queue_sample(5'h0B);
        drain();

        // Extreme settings, with a counter-saturating lost run in the first.
        write_reg(CFG_SMOOTH_WEIGHT, CFG_DATA_W'(0));
        write_reg(CFG_LOST_STEP, CFG_DATA_W'(1023));
        write_reg(CFG_LOST_CAP, CFG_DATA_W'(1023));
        queue_sample(5'h0F);
        repeat (260) queue_sample(ALL_DARK);
        queue_sample(5'h1E);
        drain();
        run_phase(0, 1023, 1023, 0, 0, 100);
        run_phase(256, 0, 1023, 60, 0, 100);
        run_phase(300, 154, 0, 0, 60, 100);
        run_phase(511, 1, 1023, 15, 15, 100);

        // Random settings; the weight is sometimes above one.
        for (int p = 0; p < 8; p++) begin
            run_phase(($urandom_range(3, 0) == 0) ? $urandom_range(511, 257)
                                                  : $urandom_range(256, 0),
                      $urandom_range(1023, 0), $urandom_range(1023, 0),
                      (p % 4 == 1) ? 60 : ((p % 4 == 3) ? 15 : 0),
                      (p % 4 == 2) ? 60 : ((p % 4 == 3) ? 15 : 0),
                      100);
        end

        if (error_count == 0) begin
            $display("** line_position_error_tracker: PASSED **");
        end else begin
            $display("** line_position_error_tracker: FAILED **");
        end
        $finish;
    end

endmodule
